/* rtl/cipid_pkg.sv */
// cipid_pkg: widths, register map, reset values and shared structs of the
// cascaded incremental PID steering block. No dependencies.
package cipid_pkg;

	// Field widths.
	localparam int GAIN_W  = 16;
	localparam int ANGLE_W = 9;
	localparam int GYRO_W  = 16;
	localparam int DRIVE_W = 16;
	localparam int LIMIT_W = 15;

	// Gain fraction bits: default and the smallest supported value. The internal
	// widths below are sized for the smallest value, which gives the largest increment.
	localparam int GAIN_FRAC_BITS_DEF = 8;
	localparam int GAIN_FRAC_BITS_MIN = 4;

	// Outer error: target (9b) minus a positive angle, -511..254.
	localparam int OE_W = ANGLE_W + 2;
	// Outer PID sum stays below 2^28, so the increment needs 29 - frac bits.
	localparam int OSUM_W = 29;
	localparam int OI_W   = OSUM_W - GAIN_FRAC_BITS_MIN;
	// Inner error: outer increment minus gyro rate.
	localparam int EI_W   = OI_W + 1;
	// Serial MAC operand: widest is e - 2*e1 + e2 of the inner loop.
	localparam int OP_W   = EI_W + 2;
	// Accumulator of the shift-right multiplier, holds a sum of three operands.
	localparam int ACC_W  = OP_W + 2;
	localparam int PROD_W = ACC_W + GAIN_W;

	// APB map: register i at byte address 4*i.
	localparam int APB_DW = 32;
	localparam int ADDR_W = 5;

	typedef logic signed [OP_W-1:0]   op_t;
	typedef logic signed [PROD_W-1:0] prod_t;

	typedef enum logic [ADDR_W-3:0] {
		REG_OUTER_KP = 3'd0,
		REG_OUTER_KI = 3'd1,
		REG_OUTER_KD = 3'd2,
		REG_INNER_KP = 3'd3,
		REG_INNER_KI = 3'd4,
		REG_INNER_KD = 3'd5,
		REG_TARGET   = 3'd6,
		REG_LIMIT    = 3'd7
	} reg_idx_t;

	localparam logic [GAIN_W-1:0]         RST_OUTER_KP = 16'd384;
	localparam logic [GAIN_W-1:0]         RST_OUTER_KI = 16'd640;
	localparam logic [GAIN_W-1:0]         RST_OUTER_KD = 16'd128;
	localparam logic [GAIN_W-1:0]         RST_INNER_KP = 16'd512;
	localparam logic [GAIN_W-1:0]         RST_INNER_KI = 16'd896;
	localparam logic [GAIN_W-1:0]         RST_INNER_KD = 16'd77;
	localparam logic signed [ANGLE_W-1:0] RST_TARGET   = 9'sd90;
	localparam logic [LIMIT_W-1:0]        RST_LIMIT    = 15'd1200;

	typedef struct packed {
		logic [GAIN_W-1:0]         outer_kp;
		logic [GAIN_W-1:0]         outer_ki;
		logic [GAIN_W-1:0]         outer_kd;
		logic [GAIN_W-1:0]         inner_kp;
		logic [GAIN_W-1:0]         inner_ki;
		logic [GAIN_W-1:0]         inner_kd;
		logic signed [ANGLE_W-1:0] target_angle;
		logic [LIMIT_W-1:0]        drive_limit;
	} cfg_t;

	// Request to the serial MAC: start pulse, gains and the three operands.
	typedef struct packed {
		logic              start;
		logic [GAIN_W-1:0] kp;
		logic [GAIN_W-1:0] ki;
		logic [GAIN_W-1:0] kd;
		op_t               a;
		op_t               b;
		op_t               c;
	} mac_req_t;

	typedef struct packed {
		logic  done;
		prod_t result;
	} mac_rsp_t;

endpackage

/* rtl/cipid_if.sv */
// cipid_in_if / cipid_out_if: valid/ready channels for samples and drive results.
// Depends on cipid_pkg.
interface cipid_in_if import cipid_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [ANGLE_W-1:0] measured_angle;
	logic signed [GYRO_W-1:0]  gyro_rate;

	modport source(output valid, measured_angle, gyro_rate, input ready);
	modport sink(input valid, measured_angle, gyro_rate, output ready);
endinterface

interface cipid_out_if import cipid_pkg::*; ();
	logic                      valid;
	logic                      ready;
	logic signed [DRIVE_W-1:0] drive_value;
	logic                      loop_active;

	modport source(output valid, drive_value, loop_active, input ready);
	modport sink(input valid, drive_value, loop_active, output ready);
endinterface

/* rtl/cipid_regs.sv */
// cipid_regs: APB register file for gains, setpoint and drive limit.
// Depends on cipid_pkg.
module cipid_regs import cipid_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	output cfg_t              cfg
);

	cfg_t     cfg_q;
	reg_idx_t idx;
	logic     wr_en;

	assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);
	assign wr_en  = psel && penable && pwrite;
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.outer_kp     <= RST_OUTER_KP;
			cfg_q.outer_ki     <= RST_OUTER_KI;
			cfg_q.outer_kd     <= RST_OUTER_KD;
			cfg_q.inner_kp     <= RST_INNER_KP;
			cfg_q.inner_ki     <= RST_INNER_KI;
			cfg_q.inner_kd     <= RST_INNER_KD;
			cfg_q.target_angle <= RST_TARGET;
			cfg_q.drive_limit  <= RST_LIMIT;
		end else if (wr_en) begin
			unique case (idx)
				REG_OUTER_KP: cfg_q.outer_kp     <= pwdata[GAIN_W-1:0];
				REG_OUTER_KI: cfg_q.outer_ki     <= pwdata[GAIN_W-1:0];
				REG_OUTER_KD: cfg_q.outer_kd     <= pwdata[GAIN_W-1:0];
				REG_INNER_KP: cfg_q.inner_kp     <= pwdata[GAIN_W-1:0];
				REG_INNER_KI: cfg_q.inner_ki     <= pwdata[GAIN_W-1:0];
				REG_INNER_KD: cfg_q.inner_kd     <= pwdata[GAIN_W-1:0];
				REG_TARGET:   cfg_q.target_angle <= pwdata[ANGLE_W-1:0];
				REG_LIMIT:    cfg_q.drive_limit  <= pwdata[LIMIT_W-1:0];
			endcase
		end
	end

	always_comb begin
		unique case (idx)
			REG_OUTER_KP: prdata = APB_DW'(cfg_q.outer_kp);
			REG_OUTER_KI: prdata = APB_DW'(cfg_q.outer_ki);
			REG_OUTER_KD: prdata = APB_DW'(cfg_q.outer_kd);
			REG_INNER_KP: prdata = APB_DW'(cfg_q.inner_kp);
			REG_INNER_KI: prdata = APB_DW'(cfg_q.inner_ki);
			REG_INNER_KD: prdata = APB_DW'(cfg_q.inner_kd);
			REG_TARGET:   prdata = APB_DW'(cfg_q.target_angle);
			REG_LIMIT:    prdata = APB_DW'(cfg_q.drive_limit);
		endcase
	end

endmodule

/* rtl/cipid_mac.sv */
// cipid_mac: bit-serial kp*a + ki*b + kd*c, one gain bit per cycle, then a
// divide by 2^frac truncated toward zero. Depends on cipid_pkg.
module cipid_mac import cipid_pkg::*; #(
	parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  mac_req_t req,
	output mac_rsp_t rsp
);

	localparam int                CntW     = $clog2(GAIN_W);
	localparam logic [CntW-1:0]   LastCnt  = CntW'(GAIN_W - 1);
	localparam logic [GAIN_W-1:0] FracMask = GAIN_W'((1 << GAIN_FRAC_BITS) - 1);

	typedef logic signed [ACC_W-1:0] acc_t;
	typedef logic signed [ACC_W:0]   sum_t;

	logic              run_q, fin_q, done_q;
	logic [CntW-1:0]   cnt_q;
	logic [GAIN_W-1:0] gp_q, gi_q, gd_q;   // gain shift registers, LSB first
	op_t               a_q, b_q, c_q;
	acc_t              acc_q;
	logic [GAIN_W-1:0] low_q;              // product bits shifted out below acc
	prod_t             result_q;

	op_t   pa, pb, pc;
	acc_t  term;
	sum_t  sum;
	prod_t prod, floor_v;
	logic  round_up;

	always_comb begin
		pa       = gp_q[0] ? a_q : '0;
		pb       = gi_q[0] ? b_q : '0;
		pc       = gd_q[0] ? c_q : '0;
		term     = acc_t'(pa) + acc_t'(pb) + acc_t'(pc);
		sum      = sum_t'(acc_q) + sum_t'(term);
		prod     = prod_t'({acc_q, low_q});
		floor_v  = prod >>> GAIN_FRAC_BITS;
		// floor to truncation: bump negative sums with a nonzero fraction
		round_up = prod[PROD_W-1] && (|(low_q & FracMask));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			fin_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= fin_q;
			fin_q  <= run_q && (cnt_q == LastCnt);
			if (req.start) begin
				run_q <= 1'b1;
				cnt_q <= '0;
			end else if (run_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == LastCnt) begin
					run_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			gp_q  <= req.kp;
			gi_q  <= req.ki;
			gd_q  <= req.kd;
			a_q   <= req.a;
			b_q   <= req.b;
			c_q   <= req.c;
			acc_q <= '0;
			low_q <= '0;
		end else if (run_q) begin
			gp_q  <= gp_q >> 1;
			gi_q  <= gi_q >> 1;
			gd_q  <= gd_q >> 1;
			acc_q <= sum[ACC_W:1];
			low_q <= {sum[0], low_q[GAIN_W-1:1]};
		end
		if (fin_q) begin
			result_q <= floor_v + (round_up ? prod_t'(1) : prod_t'(0));
		end
	end

	assign rsp.done   = done_q;
	assign rsp.result = result_q;

endmodule

/* rtl/cascaded_incremental_pid_steer.sv */
// cascaded_incremental_pid_steer: top level, sequencer, loop state and result
// register. Depends on cipid_pkg, cipid_if, cipid_regs, cipid_mac.

// Steering controller with an outer angle loop feeding an inner gyro-rate loop,
// both incremental PIDs with unsigned Q(16-f).f gains (f = GAIN_FRAC_BITS, 8 by
// default). A sample with a zero or negative angle leaves all loop state alone
// and returns the last drive with loop_active low. A positive angle runs the
// outer PID on target_angle - measured_angle, takes its integer increment minus
// gyro_rate as the inner error, runs the inner PID and clamps the result to
// +/- drive_limit; each PID sum is divided by 2^f truncating toward zero. Both
// PIDs share one bit-serial multiply-accumulate that takes one gain bit per
// cycle. An active sample passes acceptance, then per loop an operand setup
// state, the serial MAC over every gain bit, a truncation step and a handoff,
// and finally the result write. The next sample is accepted once the sequencer
// is back in idle, which can be while the previous result still sits unclaimed
// in the output register; it stalls only in its own result write if that
// register is still full. Gains, target and limit sit in an APB register file
// (register i at byte 4*i) and should be written only while the block is idle.
module cascaded_incremental_pid_steer import cipid_pkg::*; #(
	parameter int GAIN_FRAC_BITS = GAIN_FRAC_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready,
	cipid_in_if.sink          sample,
	cipid_out_if.source       result
);

	typedef enum logic [5:0] {
		ST_IDLE    = 6'b000001,
		ST_START_O = 6'b000010,
		ST_WAIT_O  = 6'b000100,
		ST_START_I = 6'b001000,
		ST_WAIT_I  = 6'b010000,
		ST_WRITE   = 6'b100000
	} state_t;

	typedef logic signed [OE_W-1:0]    oe_t;
	typedef logic signed [OI_W-1:0]    oi_t;
	typedef logic signed [EI_W-1:0]    ei_t;
	typedef logic signed [DRIVE_W-1:0] drive_t;

	cfg_t     cfg;
	mac_req_t mac_req;
	mac_rsp_t mac_rsp;

	state_t state_q;

	// current sample
	oe_t                      e_q;
	logic signed [GYRO_W-1:0] gyro_q;
	ei_t                      ei_q;
	logic                     act_q;

	// error history of both loops and the held drive
	oe_t    oe1_q, oe2_q;
	ei_t    ie1_q, ie2_q;
	drive_t held_q;

	// output register
	logic   out_valid_q;
	drive_t drive_q;
	logic   active_q;

	logic   accept, angle_off, out_free;
	oe_t    e_new;
	oi_t    outer_inc;
	ei_t    ei_new;
	prod_t  lim_pos, lim_neg;
	drive_t clamped;

	cipid_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cipid_mac #(
		.GAIN_FRAC_BITS (GAIN_FRAC_BITS)
	) u_mac (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (mac_req),
		.rsp    (mac_rsp)
	);

	assign sample.ready = (state_q == ST_IDLE);
	assign accept       = sample.valid && sample.ready;
	assign angle_off    = sample.measured_angle[ANGLE_W-1] || (sample.measured_angle == '0);
	assign e_new        = oe_t'(cfg.target_angle) - oe_t'(sample.measured_angle);
	assign out_free     = !out_valid_q || result.ready;

	// outer increment always fits OI_W; the inner error adds one bit for the gyro
	assign outer_inc = mac_rsp.result[OI_W-1:0];
	assign ei_new    = ei_t'(outer_inc) - ei_t'(gyro_q);

	// clamp the full-width inner increment before narrowing
	always_comb begin
		lim_pos = prod_t'({1'b0, cfg.drive_limit});
		lim_neg = -lim_pos;
		priority if (mac_rsp.result >= lim_pos) begin
			clamped = drive_t'(lim_pos);
		end else if (mac_rsp.result <= lim_neg) begin
			clamped = drive_t'(lim_neg);
		end else begin
			clamped = mac_rsp.result[DRIVE_W-1:0];
		end
	end

	// MAC request: outer loop operands from the angle error history, inner from the rate
	always_comb begin
		mac_req.start = (state_q == ST_START_O) || (state_q == ST_START_I);
		if (state_q == ST_START_I) begin
			mac_req.kp = cfg.inner_kp;
			mac_req.ki = cfg.inner_ki;
			mac_req.kd = cfg.inner_kd;
			mac_req.a  = op_t'(ei_q) - op_t'(ie1_q);
			mac_req.b  = op_t'(ei_q);
			mac_req.c  = op_t'(ei_q) - (op_t'(ie1_q) <<< 1) + op_t'(ie2_q);
		end else begin
			mac_req.kp = cfg.outer_kp;
			mac_req.ki = cfg.outer_ki;
			mac_req.kd = cfg.outer_kd;
			mac_req.a  = op_t'(e_q) - op_t'(oe1_q);
			mac_req.b  = op_t'(e_q);
			mac_req.c  = op_t'(e_q) - (op_t'(oe1_q) <<< 1) + op_t'(oe2_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			act_q       <= 1'b0;
			oe1_q       <= '0;
			oe2_q       <= '0;
			ie1_q       <= '0;
			ie2_q       <= '0;
			held_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a new result may load in the same cycle the old one is taken
			if ((state_q == ST_WRITE) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && result.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						act_q   <= !angle_off;
						state_q <= angle_off ? ST_WRITE : ST_START_O;
					end
				end
				ST_START_O: state_q <= ST_WAIT_O;
				ST_WAIT_O: begin
					if (mac_rsp.done) begin
						oe2_q   <= oe1_q;
						oe1_q   <= e_q;
						state_q <= ST_START_I;
					end
				end
				ST_START_I: state_q <= ST_WAIT_I;
				ST_WAIT_I: begin
					if (mac_rsp.done) begin
						ie2_q   <= ie1_q;
						ie1_q   <= ei_q;
						held_q  <= clamped;
						state_q <= ST_WRITE;
					end
				end
				ST_WRITE: begin
					// held_q is already the new drive on an active tick
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			e_q    <= e_new;
			gyro_q <= sample.gyro_rate;
		end
		if ((state_q == ST_WAIT_O) && mac_rsp.done) begin
			ei_q <= ei_new;
		end
		if ((state_q == ST_WRITE) && out_free) begin
			drive_q  <= held_q;
			active_q <= act_q;
		end
	end

	assign result.valid       = out_valid_q;
	assign result.drive_value = drive_q;
	assign result.loop_active = active_q;

endmodule
